>>> sv/oms_pkg.sv
package oms_pkg;

  // Geometry
  localparam int MAX_COLS       = 4096;
  localparam int OVERSCAN_WIDTH = 64;
  localparam int LINE_AW        = $clog2(MAX_COLS);
  localparam int OVS_AW         = (OVERSCAN_WIDTH > 1) ? $clog2(OVERSCAN_WIDTH) : 1;
  localparam int MED_IDX        = OVERSCAN_WIDTH / 2;

  // Field widths
  localparam int REG_W  = 13;
  localparam int PIX_W  = 16;
  localparam int CORR_W = 17;
  localparam int OUT_W  = 12;

  // Configuration register indexes
  localparam logic [2:0] REG_BIAS_A_START = 3'd0;
  localparam logic [2:0] REG_BIAS_B_START = 3'd1;
  localparam logic [2:0] REG_TRIM_X_FIRST = 3'd2;
  localparam logic [2:0] REG_TRIM_X_LAST  = 3'd3;
  localparam logic [2:0] REG_TRIM_Y_FIRST = 3'd4;
  localparam logic [2:0] REG_TRIM_Y_LAST  = 3'd5;
  localparam logic [2:0] REG_AMP_A_FIRST  = 3'd6;
  localparam logic [2:0] REG_AMP_A_END    = 3'd7;

  // One value moving along the sort chain
  typedef struct packed {
    logic             v;
    logic [PIX_W-1:0] d;
  } sort_beat_t;

endpackage

>>> sv/overscan_median_correction.sv
// Overscan median correction for a two-amplifier CCD pixel stream.
// Input beats (s_axis): raw pixels in raster order; tuser high marks a flush
// beat that only releases pending output. tlast marks the last pixel of a row.
// Output beats (m_axis): trimmed, bias-corrected pixels of the previous row,
// at most one per input beat; tlast marks the last trimmed pixel of a row.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i. The user
// must write only while idle; the block itself does not enforce this. Input
// beats are taken only when idle, each done before the next: one that releases
// an output passes a line store read, then an emit that registers the output,
// then the write state; a row-end beat then reads both strips from their stores
// one entry a cycle into chains of insertion cells, which then settle. A waiting
// output beat is held in its register; the next input beat is still taken, and
// the block stalls only when it has a new output to place.
// Reset clears all control state, medians and pending work; store contents
// stay undefined until written.
module overscan_median_correction (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // column[12:0], row[25:13], pixel[41:26]
  input  logic        s_axis_tuser,  // kind[0]
  input  logic        s_axis_tlast,  // row_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // corrected[16:0], out_column[28:17], out_row[40:29]
  output logic        m_axis_tlast   // row_last
);

  localparam int RW = oms_pkg::REG_W;
  localparam int PW = oms_pkg::PIX_W;
  localparam int CW = $clog2(2 * oms_pkg::OVERSCAN_WIDTH + 3);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_EMIT  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_SORT  = 3'd4;

  // Configuration registers
  logic [RW-1:0] bias_a_q, bias_b_q, tx_first_q, tx_last_q;
  logic [RW-1:0] ty_first_q, ty_last_q, amp_first_q, amp_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_a_q    <= RW'(1);
      bias_b_q    <= RW'(1);
      tx_first_q  <= RW'(1);
      tx_last_q   <= RW'(4096);
      ty_first_q  <= RW'(1);
      ty_last_q   <= RW'(4096);
      amp_first_q <= RW'(1);
      amp_end_q   <= RW'(2048);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        oms_pkg::REG_BIAS_A_START: bias_a_q    <= cfg_data_i;
        oms_pkg::REG_BIAS_B_START: bias_b_q    <= cfg_data_i;
        oms_pkg::REG_TRIM_X_FIRST: tx_first_q  <= cfg_data_i;
        oms_pkg::REG_TRIM_X_LAST:  tx_last_q   <= cfg_data_i;
        oms_pkg::REG_TRIM_Y_FIRST: ty_first_q  <= cfg_data_i;
        oms_pkg::REG_TRIM_Y_LAST:  ty_last_q   <= cfg_data_i;
        oms_pkg::REG_AMP_A_FIRST:  amp_first_q <= cfg_data_i;
        oms_pkg::REG_AMP_A_END:    amp_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q;
  logic          rd_v_q;
  logic [PW-1:0] med_a_q, med_b_q;
  logic [RW-1:0] rel_q, pend_cnt_q, pend_first_q;
  logic [11:0]   pend_row_q;
  logic          out_v_q;

  // Latched input beat
  logic          kind_q, rend_q;
  logic [RW-1:0] col_q, row_q;
  logic [PW-1:0] pix_q;

  // Output register payload
  logic [oms_pkg::CORR_W-1:0] corr_q;
  logic [11:0]                ocol_q, orow_q;
  logic                       olast_q;

  logic          pending, out_free;
  logic [RW-1:0] rel_x, col_m1, off_a, off_b, trim_first, trim_last;
  logic          amp_is_a, row_in_trim;
  logic [PW-1:0] line_rdata, ovs_a_rdata, ovs_b_rdata, med_a_new, med_b_new;
  logic          line_we, ovs_a_we, ovs_b_we;
  logic          sort_clr, sort_done;
  oms_pkg::sort_beat_t beat_a, beat_b;

  assign pending   = rel_q < pend_cnt_q;
  assign out_free  = !out_v_q || m_axis_tready;
  assign rel_x     = pend_first_q + rel_q;
  assign amp_is_a  = (rel_x >= amp_first_q) && (rel_x < amp_end_q);
  assign col_m1    = col_q - RW'(1);
  assign off_a     = col_q - bias_a_q;
  assign off_b     = col_q - bias_b_q;
  assign sort_clr  = (state_q == ST_WRITE);
  assign sort_done = (cnt_q == CW'(2 * oms_pkg::OVERSCAN_WIDTH + 2));

  // Write enables for the line store and both strips
  assign line_we  = (state_q == ST_WRITE) && !kind_q && (col_q >= RW'(1))
                    && ({1'b0, col_q} <= (RW+1)'(oms_pkg::MAX_COLS));
  assign ovs_a_we = (state_q == ST_WRITE) && !kind_q && (col_q >= bias_a_q)
                    && ({1'b0, off_a} < (RW+1)'(oms_pkg::OVERSCAN_WIDTH));
  assign ovs_b_we = (state_q == ST_WRITE) && !kind_q && (col_q >= bias_b_q)
                    && ({1'b0, off_b} < (RW+1)'(oms_pkg::OVERSCAN_WIDTH));

  // Trim window for the next pending row
  assign trim_first  = (tx_first_q == '0) ? RW'(1) : tx_first_q;
  assign trim_last   = ({1'b0, tx_last_q} > (RW+1)'(oms_pkg::MAX_COLS))
                       ? RW'(oms_pkg::MAX_COLS) : tx_last_q;
  assign row_in_trim = (row_q >= ty_first_q) && (row_q <= ty_last_q);

  oms_ram #(.WIDTH(PW), .DEPTH(oms_pkg::MAX_COLS)) u_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (oms_pkg::LINE_AW'(col_m1)),
    .wdata_i (pix_q),
    .raddr_i (oms_pkg::LINE_AW'(rel_x - RW'(1))),
    .rdata_o (line_rdata)
  );

  oms_ram #(.WIDTH(PW), .DEPTH(oms_pkg::OVERSCAN_WIDTH)) u_ovs_a (
    .clk_i   (clk_i),
    .we_i    (ovs_a_we),
    .waddr_i (oms_pkg::OVS_AW'(off_a)),
    .wdata_i (pix_q),
    .raddr_i (oms_pkg::OVS_AW'(cnt_q)),
    .rdata_o (ovs_a_rdata)
  );

  oms_ram #(.WIDTH(PW), .DEPTH(oms_pkg::OVERSCAN_WIDTH)) u_ovs_b (
    .clk_i   (clk_i),
    .we_i    (ovs_b_we),
    .waddr_i (oms_pkg::OVS_AW'(off_b)),
    .wdata_i (pix_q),
    .raddr_i (oms_pkg::OVS_AW'(cnt_q)),
    .rdata_o (ovs_b_rdata)
  );

  assign beat_a.v = rd_v_q;
  assign beat_a.d = ovs_a_rdata;
  assign beat_b.v = rd_v_q;
  assign beat_b.d = ovs_b_rdata;

  oms_sorter u_sort_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (sort_clr),
    .beat_i   (beat_a),
    .median_o (med_a_new)
  );

  oms_sorter u_sort_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (sort_clr),
    .beat_i   (beat_b),
    .median_o (med_b_new)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = pending ? ST_READ : ST_WRITE;
      ST_READ:  state_d = ST_EMIT;
      ST_EMIT:  if (out_free) state_d = ST_WRITE;
      ST_WRITE: state_d = (!kind_q && rend_q) ? ST_SORT : ST_IDLE;
      ST_SORT:  if (sort_done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      rd_v_q       <= 1'b0;
      med_a_q      <= '0;
      med_b_q      <= '0;
      rel_q        <= '0;
      pend_cnt_q   <= '0;
      pend_first_q <= RW'(1);
      pend_row_q   <= '0;
      out_v_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= (state_q == ST_SORT)
                 && ({1'b0, cnt_q} < (CW+1)'(oms_pkg::OVERSCAN_WIDTH));
      if (state_q == ST_WRITE) begin
        cnt_q <= '0;
      end else if (state_q == ST_SORT) begin
        cnt_q <= cnt_q + CW'(1);
      end
      // Output register
      if (state_q == ST_EMIT && out_free) begin
        out_v_q <= 1'b1;
        rel_q   <= rel_q + RW'(1);
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      // Row end: new medians and new pending work
      if (state_q == ST_SORT && sort_done) begin
        med_a_q <= med_a_new;
        med_b_q <= med_b_new;
        rel_q   <= '0;
        if (row_in_trim) begin
          pend_cnt_q   <= (trim_last >= trim_first)
                          ? trim_last - trim_first + RW'(1) : '0;
          pend_first_q <= trim_first;
          pend_row_q   <= 12'(row_q - ty_first_q);
        end else begin
          pend_cnt_q <= '0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      kind_q <= s_axis_tuser;
      rend_q <= s_axis_tlast;
      col_q  <= s_axis_tdata[12:0];
      row_q  <= s_axis_tdata[25:13];
      pix_q  <= s_axis_tdata[41:26];
    end
    if (state_q == ST_EMIT && out_free) begin
      corr_q  <= {1'b0, line_rdata} - {1'b0, (amp_is_a ? med_a_q : med_b_q)};
      ocol_q  <= 12'(rel_q);
      orow_q  <= pend_row_q;
      olast_q <= (rel_q + RW'(1)) == pend_cnt_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, orow_q, ocol_q, corr_q};
  assign m_axis_tlast  = olast_q;

endmodule

>>> sv/oms_ram.sv
module oms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/oms_cell.sv
module oms_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            clr_i,
  input  oms_pkg::sort_beat_t             beat_i,
  output oms_pkg::sort_beat_t             beat_o,
  output logic [oms_pkg::PIX_W-1:0]       val_o
);

  logic                      full_q;
  logic [oms_pkg::PIX_W-1:0] val_q;
  logic                      pass_v_q;
  logic [oms_pkg::PIX_W-1:0] pass_d_q;

  // Insertion cell: keep the smaller value, hand the larger one on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q   <= 1'b0;
      pass_v_q <= 1'b0;
    end else if (clr_i) begin
      full_q   <= 1'b0;
      pass_v_q <= 1'b0;
    end else if (beat_i.v) begin
      if (!full_q) begin
        full_q   <= 1'b1;
        pass_v_q <= 1'b0;
      end else begin
        pass_v_q <= 1'b1;
      end
    end else begin
      pass_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i.v) begin
      if (!full_q) begin
        val_q <= beat_i.d;
      end else if (beat_i.d < val_q) begin
        val_q    <= beat_i.d;
        pass_d_q <= val_q;
      end else begin
        pass_d_q <= beat_i.d;
      end
    end
  end

  assign beat_o = {pass_v_q, pass_d_q};
  assign val_o  = val_q;

endmodule

>>> sv/oms_sorter.sv
module oms_sorter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clr_i,
  input  oms_pkg::sort_beat_t       beat_i,
  output logic [oms_pkg::PIX_W-1:0] median_o
);

  oms_pkg::sort_beat_t       link [oms_pkg::OVERSCAN_WIDTH+1];
  logic [oms_pkg::PIX_W-1:0] vals [oms_pkg::OVERSCAN_WIDTH];

  assign link[0] = beat_i;

  // Row of insertion cells, ascending from cell 0
  for (genvar g = 0; g < oms_pkg::OVERSCAN_WIDTH; g++) begin : g_cell
    oms_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .clr_i  (clr_i),
      .beat_i (link[g]),
      .beat_o (link[g+1]),
      .val_o  (vals[g])
    );
  end

  assign median_o = vals[oms_pkg::MED_IDX];

endmodule

>>> sv/oms_checker.sv
module oms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // No output beat while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // A new output beat must follow an accepted input beat
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3))
    else $error("output beat without input beat");

  // One input beat is worked on at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken back to back");

  // Stalled output data holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled output changed");

endmodule

bind overscan_median_correction oms_checker u_oms_checker (.*);
